>>> design/assert_macros.svh
// Assertion macros shared by the ring grant arbiter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define RRGA_CHK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");

// Check that an antecedent implies a consequent in the same cycle.
`define RRGA_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that an antecedent implies a consequent in the next cycle.
`define RRGA_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> design/rrga_pkg.sv
// Shared constants and types for the ring grant arbiter.
`default_nettype none
package rrga_pkg;

  localparam int MAX_SEATS = 8;
  localparam int SEAT_W    = 3;
  localparam int RING_W    = 4;
  localparam int CFG_W     = 4;

  localparam logic [1:0] ST_THINKING = 2'd0;
  localparam logic [1:0] ST_HUNGRY   = 2'd1;
  localparam logic [1:0] ST_EATING   = 2'd2;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [CFG_W-1:0] RING_RESET = CFG_W'(5);

  typedef logic [1:0] seat_st_t;

  typedef struct packed {
    logic [SEAT_W-1:0] seat;
    logic              last;
  } grant_t;

endpackage
`default_nettype wire

>>> design/rrga_outq.sv
// Two-entry grant output queue, pushes up to two words at once.
`default_nettype none
`include "assert_macros.svh"
module rrga_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_en,
  input  wire logic [1:0]      push_cnt,
  input  wire rrga_pkg::grant_t push_d0,
  input  wire rrga_pkg::grant_t push_d1,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rrga_pkg::grant_t     out_d,
  output logic [1:0]           cnt
);

  rrga_pkg::grant_t ent0_r, ent0_nxt;
  rrga_pkg::grant_t ent1_r, ent1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       cnt_pop;
  logic             pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_d     = ent0_r;
  assign cnt       = cnt_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_pop  = cnt_r;
    if (pop) begin
      ent0_nxt = ent1_r;
      cnt_pop  = cnt_r - 2'd1;
    end
    cnt_nxt = cnt_pop;
    if (push_en && (push_cnt != 2'd0)) begin
      if (cnt_pop == 2'd0) begin
        ent0_nxt = push_d0;
      end else begin
        ent1_nxt = push_d0;
      end
      // two words only ever land in an empty queue
      if (push_cnt == 2'd2) begin
        ent1_nxt = push_d1;
      end
      cnt_nxt = cnt_pop + push_cnt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `RRGA_CHK(a_cnt_max, cnt_r <= 2'd2)
  `RRGA_IMPL(a_no_overflow, push_en, ({1'b0, cnt_r} + {1'b0, push_cnt}) <= 3'd2)
  `RRGA_NEXT(a_push_visible, push_en && (push_cnt != 2'd0), cnt_r != 2'd0)

endmodule
`default_nettype wire

>>> design/ring_resource_grant_arbiter_unit.sv
// A new request is accepted only in idle, after the previous one has pushed its grants;
// each neighbor check is three reads through the single seat memory read port.
// Up to two grant words wait in an output queue while the next request runs.
// Reset (rst_n low, synchronous): all seats thinking, ring size 5, queue empty.
// Out-of-ring requests are accepted and dropped; the unit stays idle.
`default_nettype none
`include "assert_macros.svh"
module ring_resource_grant_arbiter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [2:0] seat_id, [7:3] zero
  input  wire logic       in_tuser,   // [0] req_type
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [2:0] granted_seat, [7:3] zero
  output logic            out_tlast,  // last_in_run
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data    // seats_in_use
);

  localparam int SW = rrga_pkg::SEAT_W;
  localparam int RW = rrga_pkg::RING_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WRS  = 3'd1;
  localparam logic [2:0] S_RX   = 3'd2;
  localparam logic [2:0] S_RL   = 3'd3;
  localparam logic [2:0] S_RR   = 3'd4;
  localparam logic [2:0] S_DEC  = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  function automatic logic [SW-1:0] left_of(input logic [SW-1:0] s, input logic [RW-1:0] n);
    logic [RW-1:0] l;
    l = (s == '0) ? (n - RW'(1)) : ({1'b0, s} - RW'(1));
    return l[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] right_of(input logic [SW-1:0] s, input logic [RW-1:0] n);
    logic [RW-1:0] r;
    r = ({1'b0, s} == (n - RW'(1))) ? RW'(0) : ({1'b0, s} + RW'(1));
    return r[SW-1:0];
  endfunction

  logic [2:0]                    state_r, state_nxt;
  logic [rrga_pkg::CFG_W-1:0]    cfg_r;
  logic [RW-1:0]                 ring_n;
  logic [RW-1:0]                 n_r;
  logic                          rel_r;
  logic [SW-1:0]                 s_r;
  logic [SW-1:0]                 x_r;
  logic                          second_r;
  rrga_pkg::seat_st_t            cx_r, cl_r;
  logic                          g0_r, g1_r;
  logic [SW-1:0]                 gs0_r, gs1_r;

  logic                          in_fire;
  logic                          in_req_type;
  logic [SW-1:0]                 in_seat_id;
  logic                          seat_ok;

  // seat state memory with one write and one registered read port
  rrga_pkg::seat_st_t            mem [rrga_pkg::MAX_SEATS];
  logic [rrga_pkg::MAX_SEATS-1:0] vld_r;
  rrga_pkg::seat_st_t            rd_r;
  logic                          rd_vld_r;
  rrga_pkg::seat_st_t            rd_st;
  logic                          mem_we;
  logic [SW-1:0]                 mem_wa;
  rrga_pkg::seat_st_t            mem_wd;
  logic [SW-1:0]                 mem_ra;

  logic                          grant;
  logic                          push_en;
  logic [1:0]                    push_cnt;
  rrga_pkg::grant_t              push_d0, push_d1;
  rrga_pkg::grant_t              q_d;
  logic [1:0]                    q_cnt;
  logic                          push_fits;

  assign cfg_ready   = 1'b1;
  assign in_tready   = (state_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign in_req_type = in_tuser;
  assign in_seat_id  = in_tdata[2:0];

  // clamp ring size into 2..MAX_SEATS
  always_comb begin
    if (RW'(cfg_r) < RW'(2)) begin
      ring_n = RW'(2);
    end else if (RW'(cfg_r) > RW'(rrga_pkg::MAX_SEATS)) begin
      ring_n = RW'(rrga_pkg::MAX_SEATS);
    end else begin
      ring_n = RW'(cfg_r);
    end
  end

  assign seat_ok = ({1'b0, in_seat_id} < ring_n);
  assign rd_st   = rd_vld_r ? rd_r : rrga_pkg::ST_THINKING;
  assign grant   = (cx_r == rrga_pkg::ST_HUNGRY) && (cl_r != rrga_pkg::ST_EATING) &&
                   (rd_st != rrga_pkg::ST_EATING);

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_wa    = x_r;
    mem_wd    = rrga_pkg::ST_EATING;
    mem_ra    = x_r;
    push_en   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && seat_ok) begin
          state_nxt = S_WRS;
        end
      end
      S_WRS: begin
        mem_we    = 1'b1;
        mem_wa    = s_r;
        mem_wd    = rel_r ? rrga_pkg::ST_THINKING : rrga_pkg::ST_HUNGRY;
        state_nxt = S_RX;
      end
      S_RX: begin
        mem_ra    = x_r;
        state_nxt = S_RL;
      end
      S_RL: begin
        mem_ra    = left_of(x_r, n_r);
        state_nxt = S_RR;
      end
      S_RR: begin
        mem_ra    = right_of(x_r, n_r);
        state_nxt = S_DEC;
      end
      S_DEC: begin
        mem_we    = grant;
        state_nxt = (rel_r && !second_r) ? S_RX : S_PUSH;
      end
      S_PUSH: begin
        if (push_fits) begin
          push_en   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // pack grants of one request; the later one carries last
  always_comb begin
    push_cnt     = {1'b0, g0_r} + {1'b0, g1_r};
    push_d0.seat = g0_r ? gs0_r : gs1_r;
    push_d0.last = !(g0_r && g1_r);
    push_d1.seat = gs1_r;
    push_d1.last = 1'b1;
  end

  assign push_fits = ({1'b0, q_cnt} + {1'b0, push_cnt}) <= 3'd2;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r     <= mem[mem_ra];
    rd_vld_r <= vld_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_r   <= rrga_pkg::RING_RESET;
      vld_r   <= '0;
      g0_r    <= 1'b0;
      g1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
      end
      if (state_r == S_WRS) begin
        g0_r <= 1'b0;
        g1_r <= 1'b0;
      end
      if (state_r == S_DEC) begin
        if (second_r) begin
          g1_r <= grant;
        end else begin
          g0_r <= grant;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rel_r <= (in_req_type == rrga_pkg::REQ_RELEASE);
      s_r   <= in_seat_id;
      n_r   <= ring_n;
    end
    case (state_r)
      S_WRS: begin
        x_r      <= rel_r ? left_of(s_r, n_r) : s_r;
        second_r <= 1'b0;
      end
      S_RL: begin
        cx_r <= rd_st;
      end
      S_RR: begin
        cl_r <= rd_st;
      end
      S_DEC: begin
        if (second_r) begin
          gs1_r <= x_r;
        end else begin
          gs0_r <= x_r;
        end
        // advance to the right neighbor after the left one
        if (rel_r && !second_r) begin
          x_r      <= right_of(s_r, n_r);
          second_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  rrga_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (push_en),
    .push_cnt  (push_cnt),
    .push_d0   (push_d0),
    .push_d1   (push_d1),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_d     (q_d),
    .cnt       (q_cnt)
  );

  assign out_tdata = {{(8 - SW){1'b0}}, q_d.seat};
  assign out_tlast = q_d.last;

  `RRGA_IMPL(a_second_is_release, (state_r == S_DEC) && second_r, rel_r)
  `RRGA_NEXT(a_drop_out_of_ring, in_fire && !seat_ok, state_r == S_IDLE)
  `RRGA_IMPL(a_eat_write_in_dec, mem_we && (state_r != S_WRS), state_r == S_DEC)

endmodule
`default_nettype wire

>>> test/ring_resource_grant_arbiter_unit_tb.sv
// Self-checking testbench for the ring resource grant arbiter: predicted grants vs. stream output.
`timescale 1ns / 1ps
module ring_resource_grant_arbiter_unit_tb;

  localparam int   IDLE_LIMIT  = 3000;
  localparam int   LONG_HOLD   = 400;
  localparam int   SETTLE      = 30;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;

  // predictor state
  rrga_pkg::seat_st_t seat_table [rrga_pkg::MAX_SEATS];
  logic [3:0]         ring_cfg;
  rrga_pkg::grant_t   grants_due [$];

  // pending words: [0] req_type, [3:1] seat_id
  logic [3:0] pending_words [$];
  int         queued_cnt = 0;
  int         accepted_cnt = 0;
  int         err_cnt = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         hold_cnt = 0;
  bit         long_hold_req = 1'b0;
  int         pat_left = 0;
  logic [15:0] stall_pat = '1;
  int         idle_cycles = 0;

  ring_resource_grant_arbiter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int ring_span();
    if (ring_cfg < 2) return 2;
    if (ring_cfg > rrga_pkg::MAX_SEATS) return rrga_pkg::MAX_SEATS;
    return int'(ring_cfg);
  endfunction

  // Seat s starts eating if it is hungry and neither neighbor eats.
  function automatic bit seat_dines(int s, int n);
    if (seat_table[s] == rrga_pkg::ST_HUNGRY &&
        seat_table[(s + n - 1) % n] != rrga_pkg::ST_EATING &&
        seat_table[(s + 1) % n] != rrga_pkg::ST_EATING) begin
      seat_table[s] = rrga_pkg::ST_EATING;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic serve_request(input logic kind, input logic [2:0] seat);
    int               n;
    int               s;
    rrga_pkg::grant_t run [$];
    n = ring_span();
    s = int'(seat);
    if (s >= n) return;
    if (kind == rrga_pkg::REQ_ACQUIRE) begin
      seat_table[s] = rrga_pkg::ST_HUNGRY;
      if (seat_dines(s, n)) run.push_back('{seat: 3'(s), last: 1'b0});
    end else begin
      seat_table[s] = rrga_pkg::ST_THINKING;
      if (seat_dines((s + n - 1) % n, n))
        run.push_back('{seat: 3'((s + n - 1) % n), last: 1'b0});
      if (seat_dines((s + 1) % n, n))
        run.push_back('{seat: 3'((s + 1) % n), last: 1'b0});
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) grants_due.push_back(run[i]);
  endtask

  task automatic queue_request(input logic kind, input int seat);
    pending_words.push_back({3'(seat), kind});
    queued_cnt++;
  endtask

  task automatic queue_random(input int count);
    int  n;
    int  seat;
    logic kind;
    n = ring_span();
    repeat (count) begin
      // mostly in-ring seats; a few anywhere, which may fall outside the ring
      if ($urandom_range(0, 99) < 8) seat = $urandom_range(0, 7);
      else seat = $urandom_range(0, n - 1);
      kind = ($urandom_range(0, 99) < 45) ? rrga_pkg::REQ_RELEASE : rrga_pkg::REQ_ACQUIRE;
      queue_request(kind, seat);
    end
  endtask

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || grants_due.size() != 0) @(posedge clk);
    // out-of-ring words give no grant; let any work in flight finish
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_ring(input logic [3:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    ring_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    logic [3:0] nxt_word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        serve_request(in_tuser, in_tdata[2:0]);
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          nxt_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt_word[0];
          in_tdata  <= {5'b0, nxt_word[3:1]};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, reloaded now and then; one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left = $urandom_range(16, 96);
        if ($urandom_range(0, 3) == 0) stall_pat = '1;
        else stall_pat = 16'($urandom);
      end
      pat_left--;
      out_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // monitor: compare each grant word with the oldest prediction
  always @(posedge clk) begin
    rrga_pkg::grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (grants_due.size() == 0) begin
        $error("unexpected grant word: granted_seat %0d last_in_run %0b",
               out_tdata[2:0], out_tlast);
        err_cnt++;
      end else begin
        want = grants_due.pop_front();
        if (out_tdata[2:0] !== want.seat) begin
          $error("granted_seat mismatch: expected %0d, actual %0d", want.seat, out_tdata[2:0]);
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last_in_run mismatch: expected %0b, actual %0b", want.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [3:0] ring_plan [10];
    int         item_plan [10];
    ring_plan = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd9, 4'd7, 4'd4, 4'd6};
    item_plan = '{150, 250, 120, 200, 100, 200, 150, 200, 200, 200};
    foreach (seat_table[i]) seat_table[i] = rrga_pkg::ST_THINKING;
    ring_cfg = rrga_pkg::RING_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset ring of five: blocked acquires, wakeups on release, out-of-ring seats
    queue_request(rrga_pkg::REQ_ACQUIRE, 0);
    queue_request(rrga_pkg::REQ_ACQUIRE, 1);
    queue_request(rrga_pkg::REQ_ACQUIRE, 4);
    queue_request(rrga_pkg::REQ_ACQUIRE, 2);
    queue_request(rrga_pkg::REQ_ACQUIRE, 3);
    queue_request(rrga_pkg::REQ_RELEASE, 0);
    queue_request(rrga_pkg::REQ_RELEASE, 2);
    queue_request(rrga_pkg::REQ_RELEASE, 4);
    queue_request(rrga_pkg::REQ_ACQUIRE, 1);
    queue_request(rrga_pkg::REQ_RELEASE, 0);
    queue_request(rrga_pkg::REQ_ACQUIRE, 5);
    queue_request(rrga_pkg::REQ_ACQUIRE, 7);
    queue_request(rrga_pkg::REQ_RELEASE, 6);
    // release with both neighbors hungry and free: two grants
    queue_request(rrga_pkg::REQ_RELEASE, 3);
    queue_request(rrga_pkg::REQ_RELEASE, 4);
    queue_request(rrga_pkg::REQ_RELEASE, 0);
    queue_request(rrga_pkg::REQ_RELEASE, 2);
    queue_request(rrga_pkg::REQ_ACQUIRE, 1);
    queue_request(rrga_pkg::REQ_ACQUIRE, 0);
    queue_request(rrga_pkg::REQ_ACQUIRE, 2);
    queue_request(rrga_pkg::REQ_RELEASE, 1);
    wait_idle();
    queue_random(150);
    wait_idle();

    foreach (ring_plan[p]) begin
      write_ring(ring_plan[p]);
      if (ring_plan[p] == 4'd2) begin
        // two-seat ring: the single neighbor is granted once
        queue_request(rrga_pkg::REQ_ACQUIRE, 0);
        queue_request(rrga_pkg::REQ_ACQUIRE, 1);
        queue_request(rrga_pkg::REQ_RELEASE, 0);
      end
      if (ring_plan[p] == 4'd8) long_hold_req = 1'b1;
      queue_random(item_plan[p]);
      wait_idle();
    end

    if (grants_due.size() != 0) begin
      $error("grants still expected at end: %0d", grants_due.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/rrga_pkg.sv
design/rrga_outq.sv
design/ring_resource_grant_arbiter_unit.sv
test/ring_resource_grant_arbiter_unit_tb.sv
